// ===== rtl/core/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types, mode codes and constants for the LED pattern generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

    // mode codes
    localparam logic [3:0] MODE_OFF     = 4'd0;
    localparam logic [3:0] MODE_ON      = 4'd1;
    localparam logic [3:0] MODE_TOGGLE  = 4'd2;
    localparam logic [3:0] MODE_BLINK0  = 4'd3;
    localparam logic [3:0] MODE_BLINK1  = 4'd4;
    localparam logic [3:0] MODE_BLINK2  = 4'd5;
    localparam logic [3:0] MODE_BLINK3  = 4'd6;
    localparam logic [3:0] MODE_FADEIN  = 4'd7;
    localparam logic [3:0] MODE_FADEOUT = 4'd8;
    localparam logic [3:0] MODE_BREATH  = 4'd9;
    localparam logic [3:0] MODE_LAST    = MODE_BREATH;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd0;
    localparam logic [1:0] REG_PULSE_MS     = 2'd1;
    localparam logic [1:0] REG_FADE_STEP_MS = 2'd2;

    // register reset values
    localparam logic       RST_ACTIVE_LEVEL = 1'b1;
    localparam logic [7:0] RST_PULSE_MS     = 8'd25;
    localparam logic [9:0] RST_FADE_STEP_MS = 10'd38;

    // fade level arithmetic
    localparam logic signed [10:0] LEVEL_STEP  = 11'sd5;
    localparam logic signed [10:0] LEVEL_MAX   = 11'sd255;
    localparam logic signed [9:0]  BREATH_WRAP = -10'sd250;
    localparam logic [7:0]         DUTY_MAX    = 8'd255;

    // action codes
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    typedef struct packed {
        logic       action;
        logic [3:0] new_mode;
    } t_item;

    typedef struct packed {
        logic       pin_level;
        logic       pwm_active;
        logic [7:0] duty;
        logic [3:0] current_mode;
    } t_result;

    typedef struct packed {
        logic       active_level;
        logic [7:0] pulse_ms;
        logic [9:0] fade_step_ms;
    } t_cfg;

    function automatic logic is_blink(input logic [3:0] m);
        return (m > MODE_TOGGLE) && (m < MODE_FADEIN);
    endfunction

    function automatic logic is_fade(input logic [3:0] m);
        return m >= MODE_FADEIN;
    endfunction

    // blink period in ms
    function automatic logic [10:0] blink_period(input logic [3:0] m);
        logic [10:0] p;
        case (m)
            MODE_BLINK0: p = 11'd2000;
            MODE_BLINK1: p = 11'd1000;
            MODE_BLINK2: p = 11'd500;
            default:     p = 11'd250;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/lpg_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lpg_cfg_regs
// APB register file: active level, blink pulse length and fade step period.
// ----------------------------------------------------------------------------
module lpg_cfg_regs
    import lpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic       r_active_level;
    logic [7:0] r_pulse_ms;
    logic [9:0] r_fade_step_ms;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= RST_ACTIVE_LEVEL;
            r_pulse_ms     <= RST_PULSE_MS;
            r_fade_step_ms <= RST_FADE_STEP_MS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ACTIVE_LEVEL: r_active_level <= pwdata[0];
                REG_PULSE_MS:     r_pulse_ms     <= pwdata[7:0];
                REG_FADE_STEP_MS: r_fade_step_ms <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_ACTIVE_LEVEL: prdata = {31'd0, r_active_level};
            REG_PULSE_MS:     prdata = {24'd0, r_pulse_ms};
            REG_FADE_STEP_MS: prdata = {22'd0, r_fade_step_ms};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{active_level: r_active_level,
                     pulse_ms:     r_pulse_ms,
                     fade_step_ms: r_fade_step_ms};

endmodule

// ===== rtl/core/lpg_in_reg.sv =====
// ----------------------------------------------------------------------------
// lpg_in_reg
// Input register stage: holds one word until the engine consumes it.
// ----------------------------------------------------------------------------
module lpg_in_reg
    import lpg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_item      i_item,
    input  logic       i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_vld;
    t_item r_item;

    // stage is free when empty or when its word moves on this cycle
    assign o_ready = !r_vld || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

// ===== rtl/core/lpg_engine.sv =====
// ----------------------------------------------------------------------------
// lpg_engine
// Mode state, period counter and fade level; computes the next state and the
// result word for one tick or mode request.
// ----------------------------------------------------------------------------
module lpg_engine
    import lpg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [3:0]        r_mode_now, n_mode_now;
    logic [3:0]        r_pend_mode, n_pend_mode;
    logic              r_pend_vld, n_pend_vld;
    logic [10:0]       r_elapsed, n_elapsed;
    logic signed [9:0] r_level, n_level;
    logic              r_lit, n_lit;

    logic              v_apply, v_start, v_end;
    logic [3:0]        v_apply_mode;
    logic [10:0]       v_elapsed;
    logic [10:0]       v_fade_period;
    logic signed [10:0] v_level;
    logic [9:0]        v_mag;
    logic [7:0]        v_mag8;

    // next state for one word
    always_comb begin
        n_mode_now    = r_mode_now;
        n_pend_mode   = r_pend_mode;
        n_pend_vld    = r_pend_vld;
        n_elapsed     = r_elapsed;
        n_level       = r_level;
        n_lit         = r_lit;
        v_apply       = 1'b0;
        v_start       = 1'b0;
        v_end         = 1'b0;
        v_apply_mode  = r_pend_mode;
        v_elapsed     = r_elapsed + 11'd1;
        v_fade_period = (i_cfg.fade_step_ms == 10'd0) ? 11'd1 : {1'b0, i_cfg.fade_step_ms};
        v_level       = {r_level[9], r_level};

        if (i_item.action == ACT_REQUEST) begin
            if (i_item.new_mode <= MODE_LAST) begin
                if (r_mode_now <= MODE_TOGGLE) begin
                    v_apply      = 1'b1;
                    v_apply_mode = i_item.new_mode;
                end else begin
                    n_pend_mode = i_item.new_mode;
                    n_pend_vld  = 1'b1;
                end
            end
        end else if (is_blink(r_mode_now)) begin
            if (v_elapsed >= blink_period(r_mode_now)) begin
                v_end = 1'b1;
            end else begin
                n_lit     = v_elapsed < {3'd0, i_cfg.pulse_ms};
                n_elapsed = v_elapsed;
            end
        end else if (is_fade(r_mode_now)) begin
            if (v_elapsed >= v_fade_period) begin
                v_end = 1'b1;
            end else begin
                n_elapsed = v_elapsed;
            end
        end

        // period end: step the level, then take a pending mode or restart
        if (v_end) begin
            case (r_mode_now)
                MODE_FADEIN: begin
                    v_level = v_level + LEVEL_STEP;
                    n_level = (v_level > LEVEL_MAX) ? 10'sd0 : v_level[9:0];
                end
                MODE_FADEOUT: begin
                    v_level = v_level - LEVEL_STEP;
                    n_level = (v_level < 11'sd0) ? 10'sd255 : v_level[9:0];
                end
                MODE_BREATH: begin
                    v_level = v_level + LEVEL_STEP;
                    n_level = (v_level > LEVEL_MAX) ? BREATH_WRAP : v_level[9:0];
                end
                default: ;
            endcase
            if (r_pend_vld) begin
                n_pend_vld   = 1'b0;
                v_apply      = 1'b1;
                v_apply_mode = r_pend_mode;
            end else begin
                v_start = 1'b1;
            end
        end

        // mode change; entering fade from a non-fade mode clears the level
        if (v_apply) begin
            if (v_apply_mode != r_mode_now) begin
                if (is_fade(v_apply_mode) && !is_fade(r_mode_now)) begin
                    n_level = 10'sd0;
                end
                n_mode_now = v_apply_mode;
            end
            v_start = 1'b1;
        end

        // start of a period or a static mode
        if (v_start) begin
            case (n_mode_now)
                MODE_OFF:    n_lit = 1'b0;
                MODE_ON:     n_lit = 1'b1;
                MODE_TOGGLE: n_lit = !n_lit;
                MODE_BLINK0, MODE_BLINK1, MODE_BLINK2, MODE_BLINK3: begin
                    n_lit     = i_cfg.pulse_ms != 8'd0;
                    n_elapsed = 11'd0;
                end
                default:     n_elapsed = 11'd0;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_now  <= MODE_OFF;
            r_pend_mode <= MODE_OFF;
            r_pend_vld  <= 1'b0;
            r_elapsed   <= 11'd0;
            r_level     <= 10'sd0;
            r_lit       <= 1'b0;
        end else if (i_fire) begin
            r_mode_now  <= n_mode_now;
            r_pend_mode <= n_pend_mode;
            r_pend_vld  <= n_pend_vld;
            r_elapsed   <= n_elapsed;
            r_level     <= n_level;
            r_lit       <= n_lit;
        end
    end

    // result from the state after this word
    always_comb begin
        v_mag  = n_level[9] ? 10'(-n_level) : n_level;
        v_mag8 = (v_mag > 10'd255) ? DUTY_MAX : v_mag[7:0];
        o_result.current_mode = n_mode_now;
        if (is_fade(n_mode_now)) begin
            o_result.pin_level  = 1'b0;
            o_result.pwm_active = 1'b1;
            o_result.duty       = i_cfg.active_level ? v_mag8 : (DUTY_MAX - v_mag8);
        end else begin
            o_result.pin_level  = ~(n_lit ^ i_cfg.active_level);
            o_result.pwm_active = 1'b0;
            o_result.duty       = 8'd0;
        end
    end

endmodule

// ===== rtl/core/led_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// led_pattern_generator
// One-LED pattern generator: static, toggle, blink and fade/breath modes
// driven by millisecond ticks and mode requests.
// ----------------------------------------------------------------------------
// path: input register, then engine, into the result register that drives o_valid
// throughput: one word per cycle unless i_ready stalls; the input and output
//   register stages let a new word enter while a finished result still waits for i_ready
// reset: synchronous active-low i_rst_n empties both stages, sets mode off,
//   LED dark, level and counter zero, and the registers to their defaults
// ----------------------------------------------------------------------------
module led_pattern_generator
    import lpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [3:0]  i_new_mode,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_pin_level,
    output logic        o_pwm_active,
    output logic [7:0]  o_duty,
    output logic [3:0]  o_current_mode,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    cfg;
    t_item   in_item;
    t_item   stage_item;
    logic    stage_vld;
    logic    advance;
    logic    fire;
    t_result result;
    logic    r_out_vld;
    t_result r_out;

    lpg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // output stage can take a new word when empty or being drained
    assign advance = !r_out_vld || i_ready;
    assign fire    = stage_vld && advance;

    // incoming word fields
    assign in_item = '{action: i_action, new_mode: i_new_mode};

    lpg_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_vld),
        .o_item    (stage_item)
    );

    lpg_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= stage_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_pin_level    = r_out.pin_level;
    assign o_pwm_active   = r_out.pwm_active;
    assign o_duty         = r_out.duty;
    assign o_current_mode = r_out.current_mode;

    // pwm drive parks the raw pin low
    a_pwm_pin_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pwm_active |-> !o_pin_level)
        else $error("pin level high while pwm drives the LED");

    // pwm flag follows the fade modes
    a_pwm_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pwm_active == (o_current_mode >= MODE_FADEIN)))
        else $error("pwm flag does not match mode");

    // duty is zero outside pwm
    a_duty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pwm_active |-> (o_duty == 8'd0))
        else $error("duty nonzero without pwm");

    // mode in effect is always a legal code
    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_current_mode <= MODE_LAST))
        else $error("illegal mode in effect");

endmodule
